>>> sv/multi_bloom_hotness_tracker_unit_defines.svh
// ---------------------------------------------------------------------------
// multi bloom hotness tracker - assertion macros
// shared concurrent assertion forms, clocked on i_clk, off while in reset
// ---------------------------------------------------------------------------
`ifndef MULTI_BLOOM_HOTNESS_TRACKER_UNIT_DEFINES_SVH
`define MULTI_BLOOM_HOTNESS_TRACKER_UNIT_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define MBHT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define MBHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/mbht_pkg.sv
// ---------------------------------------------------------------------------
// mbht_pkg
// shared constants, field widths and register codes of the hotness tracker
// ---------------------------------------------------------------------------
package mbht_pkg;

    // default sizing
    localparam int NUM_FILTERS_DEF     = 4;
    localparam int BITS_PER_FILTER_DEF = 4096;
    localparam int MAX_PROBES_DEF      = 8;

    // field widths
    localparam int HASH_W      = 64;
    localparam int WSUM_W      = 8;
    localparam int IFILT_W     = 4;
    localparam int PROBE_CNT_W = 4;
    localparam int WINDOW_W    = 25;
    localparam int THRESH_W    = 8;
    localparam int REQ_CNT_W   = 24;

    // stream packing
    localparam int IN_TDATA_W  = 2 * HASH_W;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_USED_W  = 1 + WSUM_W + 1 + IFILT_W;
    localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = WINDOW_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROBE_COUNT = 2'd0,
        CFG_DECAY_WINDOW = 2'd1,
        CFG_HOT_THRESH  = 2'd2
    } t_cfg_idx;

    // register reset values and the decay window limit
    localparam logic [PROBE_CNT_W-1:0] PROBE_CNT_RST = 4'd3;
    localparam logic [WINDOW_W-1:0]    WINDOW_RST    = 25'd1024;
    localparam logic [THRESH_W-1:0]    THRESH_RST    = 8'd6;
    localparam logic [WINDOW_W-1:0]    WINDOW_LIMIT  = 25'h100_0000;

    // opcode of an input item
    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_CHECK  = 1'b1;

endpackage

>>> sv/mbht_bitmem.sv
// ---------------------------------------------------------------------------
// mbht_bitmem
// filter bit columns: one write port, one read port with registered data
// ---------------------------------------------------------------------------
module mbht_bitmem #(
    parameter int DEPTH = mbht_pkg::BITS_PER_FILTER_DEF,
    parameter int WIDTH = mbht_pkg::NUM_FILTERS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/multi_bloom_hotness_tracker_unit.sv
// ---------------------------------------------------------------------------
// multi_bloom_hotness_tracker_unit
// hot key detector over a ring of bloom filters sharing one bit memory
// ---------------------------------------------------------------------------
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata: hash_first, hash_second
//                                               tuser: opcode
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: is_hot, weight_sum,
//                                               inserted, inserted_filter
//  cfg       in   i_cfg_wr_en                   i_cfg_index, i_cfg_data
//
//  a check is a probe pass of P probes, P the probe count in use, then
//  a scan of all NUM_FILTERS filters; an access is a probe pass, S from 1
//  to NUM_FILTERS filter scan steps, then an insert pass of P probes, with
//  no insert pass when the key sits in every filter; every probe is a read
//  then a compare or write on the shared memory; a decay adds a column
//  clearing sweep; after reset the same sweep clears the memory
//  with s_axis_tready low; a finished result waits in the output register
//  and the next item is taken meanwhile, so only a second result stalls
// ---------------------------------------------------------------------------
`include "multi_bloom_hotness_tracker_unit_defines.svh"

module multi_bloom_hotness_tracker_unit #(
    parameter int NUM_FILTERS     = mbht_pkg::NUM_FILTERS_DEF,
    parameter int BITS_PER_FILTER = mbht_pkg::BITS_PER_FILTER_DEF, // power of two
    parameter int MAX_PROBES      = mbht_pkg::MAX_PROBES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration writes
    input  logic                               i_cfg_wr_en,
    input  logic [mbht_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mbht_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input items
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [mbht_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // hash_first, hash_second
    input  logic [mbht_pkg::IN_TUSER_W-1:0]    s_axis_tuser,  // opcode
    // results
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [mbht_pkg::OUT_TDATA_W-1:0]   m_axis_tdata   // is_hot, weight_sum,
                                                              // inserted, inserted_filter, pad
);

    import mbht_pkg::*;

    localparam int ADDR_W  = $clog2(BITS_PER_FILTER);
    localparam int FI_W    = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;
    localparam int W_W     = $clog2(NUM_FILTERS + 1);
    localparam int CNT_MAX = (MAX_PROBES > NUM_FILTERS) ? MAX_PROBES : NUM_FILTERS;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);
    localparam int PAD_W   = OUT_TDATA_W - OUT_USED_W;

    typedef enum logic [8:0] {
        ST_CLEAR   = 9'b000000001,
        ST_IDLE    = 9'b000000010,
        ST_SWEEP   = 9'b000000100,
        ST_PRB_RD  = 9'b000001000,
        ST_PRB_CHK = 9'b000010000,
        ST_SCAN    = 9'b000100000,
        ST_INS_RD  = 9'b001000000,
        ST_INS_WR  = 9'b010000000,
        ST_DONE    = 9'b100000000
    } t_state;

    function automatic logic [FI_W-1:0] ring_next(input logic [FI_W-1:0] f);
        return (f == FI_W'(NUM_FILTERS - 1)) ? '0 : f + FI_W'(1);
    endfunction

    t_state n_state, r_state;

    // configuration registers
    logic [PROBE_CNT_W-1:0] r_cfg_probe;
    logic [WINDOW_W-1:0]    r_cfg_window;
    logic [THRESH_W-1:0]    r_cfg_thresh;

    // filter ring state
    logic [W_W-1:0]         r_weight [NUM_FILTERS];
    logic [FI_W-1:0]        r_cur;
    logic [FI_W-1:0]        r_old;
    logic [REQ_CNT_W-1:0]   r_req_cnt;

    // column clearing sweep
    logic [NUM_FILTERS-1:0] r_keep;
    logic [ADDR_W:0]        r_swp_cnt;
    logic                   r_swp_wr_vld;
    logic [ADDR_W-1:0]      r_swp_wr_addr;

    // per item working registers
    logic                   r_op;
    logic [ADDR_W-1:0]      r_pos;
    logic [ADDR_W-1:0]      r_base;
    logic [ADDR_W-1:0]      r_stride;
    logic [CNT_W-1:0]       r_idx;
    logic [CNT_W-1:0]       r_nprb;
    logic [NUM_FILTERS-1:0] r_mask;
    logic [FI_W-1:0]        r_scan_f;
    logic [WSUM_W-1:0]      r_sum;
    logic                   r_ins;
    logic [FI_W-1:0]        r_ins_f;

    // output register
    logic                   r_out_vld;
    logic [OUT_TDATA_W-1:0] r_out_data;

    // memory port
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [NUM_FILTERS-1:0] mem_wdata;
    logic [ADDR_W-1:0]      mem_raddr;
    logic [NUM_FILTERS-1:0] mem_rdata;

    logic                   s_fire;
    logic                   in_sweep;
    logic                   swp_end;
    logic                   last_prb;
    logic                   last_f;
    logic                   out_free;
    logic [WINDOW_W-1:0]    win_sat;
    logic [WINDOW_W-1:0]    cnt_plus;
    logic                   decay_hit;
    logic [CNT_W-1:0]       prb_used;
    logic                   res_hot;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign in_sweep      = (r_state == ST_CLEAR) || (r_state == ST_SWEEP);
    assign swp_end       = r_swp_cnt[ADDR_W];
    assign last_prb      = (r_idx + CNT_W'(1)) == r_nprb;
    assign last_f        = (r_idx + CNT_W'(1)) == CNT_W'(NUM_FILTERS);
    assign out_free      = !r_out_vld || m_axis_tready;

    // decay decision: window zero acts as one, above the limit it saturates
    assign win_sat   = (r_cfg_window > WINDOW_LIMIT) ? WINDOW_LIMIT : r_cfg_window;
    assign cnt_plus  = {1'b0, r_req_cnt} + WINDOW_W'(1);
    assign decay_hit = cnt_plus >= win_sat;

    // probe count: zero counts as one, large values clamp
    always_comb begin
        if (r_cfg_probe == '0) begin
            prb_used = CNT_W'(1);
        end else if ({1'b0, r_cfg_probe} > (PROBE_CNT_W + 1)'(MAX_PROBES)) begin
            prb_used = CNT_W'(MAX_PROBES);
        end else begin
            prb_used = CNT_W'(r_cfg_probe);
        end
    end

    assign res_hot = (r_op == OP_CHECK) && (r_sum >= r_cfg_thresh);

    // memory ports shared between sweep and probe / insert passes
    assign mem_raddr = in_sweep ? r_swp_cnt[ADDR_W-1:0] : r_pos;
    assign mem_we    = (in_sweep && r_swp_wr_vld) || (r_state == ST_INS_WR);
    assign mem_waddr = in_sweep ? r_swp_wr_addr : r_pos;
    assign mem_wdata = in_sweep ? (mem_rdata & r_keep)
                                : (mem_rdata | (NUM_FILTERS'(1) << r_ins_f));

    mbht_bitmem #(
        .DEPTH (BITS_PER_FILTER),
        .WIDTH (NUM_FILTERS)
    ) u_bitmem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (swp_end) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_axis_tuser[0] == OP_ACCESS && decay_hit) n_state = ST_SWEEP;
                    else n_state = ST_PRB_RD;
                end
            end
            ST_SWEEP: begin
                if (swp_end) n_state = ST_PRB_RD;
            end
            ST_PRB_RD: begin
                n_state = ST_PRB_CHK;
            end
            ST_PRB_CHK: begin
                n_state = last_prb ? ST_SCAN : ST_PRB_RD;
            end
            ST_SCAN: begin
                if (r_op == OP_ACCESS && !r_mask[r_scan_f]) n_state = ST_INS_RD;
                else if (last_f) n_state = ST_DONE;
            end
            ST_INS_RD: begin
                n_state = ST_INS_WR;
            end
            ST_INS_WR: begin
                n_state = last_prb ? ST_DONE : ST_INS_RD;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_cfg_probe  <= PROBE_CNT_RST;
            r_cfg_window <= WINDOW_RST;
            r_cfg_thresh <= THRESH_RST;
            for (int i = 0; i < NUM_FILTERS; i++) begin
                r_weight[i] <= W_W'(i + 1);
            end
            r_cur        <= '0;
            r_old        <= '0;
            r_req_cnt    <= '0;
            r_keep       <= '0;     // reset sweep clears every column
            r_swp_cnt    <= '0;
            r_swp_wr_vld <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_wr_en) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_PROBE_COUNT:  r_cfg_probe  <= i_cfg_data[PROBE_CNT_W-1:0];
                    CFG_DECAY_WINDOW: r_cfg_window <= i_cfg_data[WINDOW_W-1:0];
                    CFG_HOT_THRESH:   r_cfg_thresh <= i_cfg_data[THRESH_W-1:0];
                    default: ;
                endcase
            end

            // an access counts, may decay, then moves the current pointer on
            if (s_fire && s_axis_tuser[0] == OP_ACCESS) begin
                r_cur <= ring_next(r_cur);
                if (decay_hit) begin
                    r_req_cnt <= '0;
                    for (int i = 0; i < NUM_FILTERS; i++) begin
                        r_weight[i] <= (r_weight[i] <= W_W'(1)) ? W_W'(NUM_FILTERS)
                                                                : r_weight[i] - W_W'(1);
                    end
                    r_keep    <= ~(NUM_FILTERS'(1) << r_old);
                    r_old     <= ring_next(r_old);
                    r_swp_cnt <= '0;
                end else begin
                    r_req_cnt <= cnt_plus[REQ_CNT_W-1:0];
                end
            end

            // sweep reads one word a cycle and writes it back masked in the next cycle
            if (in_sweep) begin
                if (!swp_end) r_swp_cnt <= r_swp_cnt + (ADDR_W + 1)'(1);
                r_swp_wr_vld <= !swp_end;
            end

            if (r_state == ST_DONE && out_free) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_sweep) begin
            r_swp_wr_addr <= r_swp_cnt[ADDR_W-1:0];
        end

        case (r_state)
            ST_IDLE: begin
                if (s_fire) begin
                    r_op     <= s_axis_tuser[0];
                    // positions are taken modulo the filter size: low bits only
                    r_base   <= s_axis_tdata[ADDR_W-1:0];
                    r_pos    <= s_axis_tdata[ADDR_W-1:0];
                    r_stride <= s_axis_tdata[HASH_W +: ADDR_W];
                    r_idx    <= '0;
                    r_nprb   <= prb_used;
                    r_mask   <= '1;
                    r_sum    <= '0;
                    r_ins    <= 1'b0;
                    r_ins_f  <= '0;
                    r_scan_f <= (s_axis_tuser[0] == OP_CHECK) ? '0 : r_cur;
                end
            end
            ST_PRB_CHK: begin
                r_mask <= r_mask & mem_rdata;
                if (last_prb) begin
                    r_idx <= '0;
                end else begin
                    r_idx <= r_idx + CNT_W'(1);
                    r_pos <= r_pos + r_stride;
                end
            end
            ST_SCAN: begin
                if (r_op == OP_CHECK) begin
                    if (r_mask[r_scan_f]) r_sum <= r_sum + WSUM_W'(r_weight[r_scan_f]);
                    r_scan_f <= ring_next(r_scan_f);
                    r_idx    <= r_idx + CNT_W'(1);
                end else if (!r_mask[r_scan_f]) begin
                    // first filter in ring order that lacks the key
                    r_ins   <= 1'b1;
                    r_ins_f <= r_scan_f;
                    r_pos   <= r_base;
                    r_idx   <= '0;
                end else begin
                    r_scan_f <= ring_next(r_scan_f);
                    r_idx    <= r_idx + CNT_W'(1);
                end
            end
            ST_INS_WR: begin
                r_pos <= r_pos + r_stride;
                r_idx <= r_idx + CNT_W'(1);
            end
            ST_DONE: begin
                if (out_free) begin
                    r_out_data <= {{PAD_W{1'b0}}, IFILT_W'(r_ins_f), r_ins, r_sum, res_hot};
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    `MBHT_ASSERT_NEXT(a_decay_starts_sweep,
        s_fire && s_axis_tuser[0] == OP_ACCESS && decay_hit,
        r_state == ST_SWEEP && r_swp_cnt == '0 && !r_swp_wr_vld,
        "decay did not start a fresh column sweep")
    `MBHT_ASSERT_SAME(a_insert_only_on_access,
        r_state == ST_INS_WR,
        r_op == OP_ACCESS && r_ins,
        "insert pass without a chosen filter")
    `MBHT_ASSERT_SAME(a_probe_index_in_range,
        r_state == ST_PRB_CHK || r_state == ST_INS_WR,
        r_idx < r_nprb,
        "probe index beyond probe count")
    `MBHT_ASSERT_SAME(a_no_write_when_idle,
        r_state == ST_IDLE || r_state == ST_DONE,
        !mem_we,
        "memory written outside a pass")

endmodule
